[rtl/hcbd_pkg.sv]
// Package for the chunked body decoder: body part states, byte codes,
// the hex digit decoder and the result record passed between stages.
// Depends on nothing; every other file of the block imports it.
package hcbd_pkg;

    localparam int SIZE_BITS_DEFAULT = 32;

    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] CHAR_D0   = 8'h30;
    localparam logic [7:0] CHAR_D9   = 8'h39;
    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_LF   = 8'h66;
    localparam logic [7:0] CHAR_UA   = 8'h41;
    localparam logic [7:0] CHAR_UF   = 8'h46;
    localparam logic [3:0] HEX_TEN   = 4'd10;

    typedef enum logic [1:0] {
        PART_SIZE     = 2'd0,
        PART_DATA     = 2'd1,
        PART_DATA_END = 2'd2,
        PART_TRAILER  = 2'd3
    } part_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
        logic       msg_end;
    } result_t;

    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t h;
        h.ok    = 1'b0;
        h.value = 4'd0;
        if (b >= CHAR_D0 && b <= CHAR_D9)
        begin
            h.ok    = 1'b1;
            h.value = 4'(b - CHAR_D0);
        end
        else if (b >= CHAR_LA && b <= CHAR_LF)
        begin
            h.ok    = 1'b1;
            h.value = 4'(b - CHAR_LA) + HEX_TEN;
        end
        else if (b >= CHAR_UA && b <= CHAR_UF)
        begin
            h.ok    = 1'b1;
            h.value = 4'(b - CHAR_UA) + HEX_TEN;
        end
        return h;
    endfunction

endpackage

[rtl/hcbd_in_stage.sv]
// Input register of the chunked body decoder: holds one raw byte until the
// parser can take it. Imports hcbd_pkg but uses none of its items.
module hcbd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output logic       in_stall,
    input  logic       out_busy,
    output logic       step,
    output logic [7:0] step_byte
);
    import hcbd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The held item moves on unless the result register is full and stalled.
    assign step      = valid_reg && !out_busy;
    assign in_stall  = valid_reg && out_busy;
    assign step_byte = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

[rtl/hcbd_parser.sv]
// Body parser of the chunked body decoder: body part state machine, chunk
// size and position counters, line tracking and result formation.
// Depends on hcbd_pkg for the part states, byte codes and result record.
module hcbd_parser #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        step_byte,
    output hcbd_pkg::result_t res
);
    import hcbd_pkg::*;

    part_t                part_reg;
    part_t                part_next;
    logic [SIZE_BITS-1:0] len_reg;
    logic [SIZE_BITS-1:0] len_next;
    logic [SIZE_BITS-1:0] pos_reg;
    logic [SIZE_BITS-1:0] pos_next;
    logic [SIZE_BITS-1:0] pos_inc;
    logic                 hex_stopped_reg;
    logic                 hex_stopped_next;
    logic [1:0]           line_chars_reg;
    logic [1:0]           line_chars_next;
    logic                 prev_cr_reg;
    logic                 prev_cr_next;
    logic                 is_lf;
    logic                 is_cr;
    logic                 line_empty;
    logic [1:0]           line_chars_add;
    hex_t                 hex;

    assign is_lf          = (step_byte == BYTE_LF);
    assign is_cr          = (step_byte == BYTE_CR);
    assign hex            = hex_digit(step_byte);
    assign pos_inc        = pos_reg + SIZE_BITS'(1);
    assign line_chars_add = (line_chars_reg == 2'd3) ? 2'd3 : line_chars_reg + 2'd1;
    assign line_empty     = (line_chars_reg == 2'd0) || (line_chars_reg == 2'd1 && prev_cr_reg);

    always_comb
    begin
        part_next        = part_reg;
        len_next         = len_reg;
        pos_next         = pos_reg;
        hex_stopped_next = hex_stopped_reg;
        line_chars_next  = line_chars_reg;
        prev_cr_next     = prev_cr_reg;
        if (step)
        begin
            unique case (part_reg)
                PART_SIZE:
                begin
                    if (is_lf)
                    begin
                        line_chars_next  = 2'd0;
                        prev_cr_next     = 1'b0;
                        hex_stopped_next = 1'b0;
                        pos_next         = '0;
                        part_next = (len_reg == '0) ? PART_TRAILER : PART_DATA;
                    end
                    else
                    begin
                        if (!hex_stopped_reg && hex.ok)
                        begin
                            len_next = {len_reg[SIZE_BITS-5:0], hex.value};
                        end
                        else
                        begin
                            hex_stopped_next = 1'b1;
                        end
                        line_chars_next = line_chars_add;
                        prev_cr_next    = is_cr;
                    end
                end
                PART_DATA:
                begin
                    pos_next = pos_inc;
                    if (pos_inc >= len_reg)
                    begin
                        pos_next         = '0;
                        part_next        = PART_DATA_END;
                        line_chars_next  = 2'd0;
                        prev_cr_next     = 1'b0;
                        hex_stopped_next = 1'b0;
                    end
                end
                PART_DATA_END:
                begin
                    if (is_lf)
                    begin
                        line_chars_next  = 2'd0;
                        prev_cr_next     = 1'b0;
                        hex_stopped_next = 1'b0;
                        len_next         = '0;
                        part_next        = PART_SIZE;
                    end
                    else
                    begin
                        line_chars_next = line_chars_add;
                        prev_cr_next    = is_cr;
                    end
                end
                PART_TRAILER:
                begin
                    if (is_lf)
                    begin
                        line_chars_next  = 2'd0;
                        prev_cr_next     = 1'b0;
                        hex_stopped_next = 1'b0;
                        if (line_empty)
                        begin
                            len_next  = '0;
                            pos_next  = '0;
                            part_next = PART_SIZE;
                        end
                    end
                    else
                    begin
                        line_chars_next = line_chars_add;
                        prev_cr_next    = is_cr;
                    end
                end
                default:
                begin
                    part_next = PART_SIZE;
                end
            endcase
        end
    end

    always_comb
    begin
        res.vld     = 1'b0;
        res.data    = 8'd0;
        res.msg_end = 1'b0;
        unique case (part_reg)
            PART_DATA:
            begin
                res.vld  = step;
                res.data = step_byte;
            end
            PART_TRAILER:
            begin
                res.vld     = step && is_lf && line_empty;
                res.msg_end = 1'b1;
            end
            default:
            begin
                res.vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg        <= PART_SIZE;
            len_reg         <= '0;
            pos_reg         <= '0;
            hex_stopped_reg <= 1'b0;
            line_chars_reg  <= 2'd0;
            prev_cr_reg     <= 1'b0;
        end
        else
        begin
            part_reg        <= part_next;
            len_reg         <= len_next;
            pos_reg         <= pos_next;
            hex_stopped_reg <= hex_stopped_next;
            line_chars_reg  <= line_chars_next;
            prev_cr_reg     <= prev_cr_next;
        end
    end

endmodule

[rtl/hcbd_out_stage.sv]
// Result register of the chunked body decoder: holds one decoded item
// until the receiver takes it. Depends on hcbd_pkg for the result record.
module hcbd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  hcbd_pkg::result_t res,
    output logic              out_busy,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              message_end
);
    import hcbd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic       load;
    logic [7:0] byte_reg;
    logic       end_reg;

    assign out_busy    = valid_reg && out_stall;
    assign load        = !out_busy;
    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign message_end = end_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = res.vld;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.vld)
        begin
            byte_reg <= res.data;
            end_reg  <= res.msg_end;
        end
    end

endmodule

[rtl/http_chunked_body_decoder_unit.sv]
// Channel  | Signals                      | Direction | Meaning
// in       | in_valid, in_stall, in_byte  | receive   | one raw body byte per item
// out      | out_valid, out_stall,        | send      | payload byte, or end of
//          | out_byte, message_end        |           | message with a zero byte
//
// Each accepted byte passes through the input register, then through the
// parser into the result register. One byte is accepted every cycle unless
// the output stalls; the parser state update sets that figure.
// Only payload bytes and the LF closing an empty trailer line give a result.
// Reset clears the state to the size line of a new body with a zero size.
// An output stall holds the result register and, at once, the input register.
// Top level of the chunked body decoder; depends on hcbd_pkg, hcbd_in_stage,
// hcbd_parser and hcbd_out_stage.
module http_chunked_body_decoder_unit #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       message_end
);
    import hcbd_pkg::*;

    logic       out_busy;
    logic       step;
    logic [7:0] step_byte;
    result_t    res;

    hcbd_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .in_stall  (in_stall),
        .out_busy  (out_busy),
        .step      (step),
        .step_byte (step_byte)
    );

    hcbd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .step_byte (step_byte),
        .res       (res)
    );

    hcbd_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .res         (res),
        .out_busy    (out_busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .message_end (message_end)
    );

endmodule

[rtl/hcbd_checker.sv]
// Port checker for the chunked body decoder, attached by the bind below.
// Imports hcbd_pkg and reads only the ports of http_chunked_body_decoder_unit.
module hcbd_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic       message_end
);
    import hcbd_pkg::*;

    logic in_take;

    assign in_take = in_valid && !in_stall;

    // An end of message carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && message_end) |-> (out_byte == 8'd0))
    else $error("end of message with a nonzero byte");

    // A held result keeps its fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(message_end)))
    else $error("stalled result changed");

    // The input side stalls only behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

    // A quiet stretch, nothing accepted and nothing shown, is not followed by a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!in_take && !out_valid) ##1 (!in_take && !out_valid) |=> !out_valid)
    else $error("result without an accepted item");

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .message_end (message_end)
);

[test/tb.sv]
// Self-checking testbench for http_chunked_body_decoder_unit: chunked bodies go in
// byte by byte, and a local decoder predicts every payload byte and end of message.
// Depends on hcbd_pkg and the RTL of the decoder.
module tb;
    import hcbd_pkg::*;

    localparam int SIZE_BITS = SIZE_BITS_DEFAULT;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASE_BYTES = 360;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } decoded_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       message_end;

    logic [7:0] pending_bytes[$];
    decoded_t   expected_results[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int bytes_in = 0;
    int payload_seen = 0;
    int ends_seen = 0;
    int bytes_queued = 0;
    bit in_taken = 1'b0;
    bit out_taken;

    part_t                part = PART_SIZE;
    logic [SIZE_BITS-1:0] chunk_len = '0;
    logic [SIZE_BITS-1:0] chunk_pos = '0;
    bit                   digits_done = 1'b0;
    logic [1:0]           line_len = 2'd0;
    bit                   last_cr = 1'b0;

    int idle_set[4] = '{0, 70, 0, 25};
    int stall_set[4] = '{0, 0, 70, 25};

    http_chunked_body_decoder_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_byte(in_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte),
        .message_end(message_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        if (b >= CHAR_D0 && b <= CHAR_D9)
            return {1'b1, 4'(b - CHAR_D0)};
        if (b >= CHAR_LA && b <= CHAR_LA + 8'd5)
            return {1'b1, 4'(b - CHAR_LA + 8'd10)};
        if (b >= CHAR_UA && b <= CHAR_UA + 8'd5)
            return {1'b1, 4'(b - CHAR_UA + 8'd10)};
        return 5'd0;
    endfunction

    task automatic clear_line();
        line_len = 2'd0;
        last_cr = 1'b0;
        digits_done = 1'b0;
    endtask

    task automatic note_char(input logic [7:0] b);
        if (line_len != 2'd3)
            line_len = line_len + 2'd1;
        last_cr = (b == BYTE_CR);
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [4:0] nib;
        decoded_t   r;
        bit         blank;
        nib = nibble_of(b);
        case (part)
            PART_SIZE:
            begin
                if (b == BYTE_LF)
                begin
                    clear_line();
                    chunk_pos = '0;
                    part = (chunk_len == '0) ? PART_TRAILER : PART_DATA;
                end
                else
                begin
                    if (!digits_done && nib[4])
                        chunk_len = {chunk_len[SIZE_BITS-5:0], nib[3:0]};
                    else
                        digits_done = 1'b1;
                    note_char(b);
                end
            end
            PART_DATA:
            begin
                r.data = b;
                r.fin = 1'b0;
                expected_results.push_back(r);
                chunk_pos = chunk_pos + SIZE_BITS'(1);
                if (chunk_pos >= chunk_len)
                begin
                    chunk_pos = '0;
                    part = PART_DATA_END;
                    clear_line();
                end
            end
            PART_DATA_END:
            begin
                if (b == BYTE_LF)
                begin
                    clear_line();
                    chunk_len = '0;
                    part = PART_SIZE;
                end
                else
                    note_char(b);
            end
            PART_TRAILER:
            begin
                if (b == BYTE_LF)
                begin
                    blank = (line_len == 2'd0) || (line_len == 2'd1 && last_cr);
                    clear_line();
                    if (blank)
                    begin
                        chunk_len = '0;
                        chunk_pos = '0;
                        part = PART_SIZE;
                        r.data = 8'h00;
                        r.fin = 1'b1;
                        expected_results.push_back(r);
                    end
                end
                else
                    note_char(b);
            end
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        logic [4:0] nib;
        do
        begin
            b = 8'($urandom_range(0, 255));
            nib = nibble_of(b);
        end
        while (nib[4] || b == BYTE_LF);
        return b;
    endfunction

    task automatic push_digit(input int d);
        if (d < 10)
            push_byte(CHAR_D0 + 8'(d));
        else if ($urandom_range(0, 1) == 0)
            push_byte(CHAR_UA + 8'(d - 10));
        else
            push_byte(CHAR_LA + 8'(d - 10));
    endtask

    task automatic push_line_end();
        if ($urandom_range(0, 1) == 0)
            push_byte(BYTE_CR);
        push_byte(BYTE_LF);
    endtask

    task automatic push_extension();
        int n;
        if ($urandom_range(0, 3) == 0)
        begin
            push_text(";");
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                push_byte(junk_byte());
        end
    endtask

    task automatic push_size(input int unsigned n);
        int nd;
        int lead;
        nd = 1;
        while (nd < 8 && (n >> (4 * nd)) != 0)
            nd++;
        if ($urandom_range(0, 7) == 0)
        begin
            lead = $urandom_range(1, 3);
            for (int i = 0; i < lead; i++)
                push_digit($urandom_range(1, 15));
            nd = 8;
        end
        else
        begin
            lead = $urandom_range(0, 2);
            for (int i = 0; i < lead; i++)
                push_digit(0);
        end
        for (int i = nd - 1; i >= 0; i--)
            push_digit((n >> (4 * i)) & 15);
    endtask

    task automatic push_message();
        int chunks;
        int size;
        int n;
        int pick;
        logic [7:0] b;
        chunks = $urandom_range(0, 3);
        for (int c = 0; c < chunks; c++)
        begin
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            push_size(size);
            push_extension();
            push_line_end();
            for (int i = 0; i < size; i++)
                push_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    push_byte(junk_byte());
            end
            push_line_end();
        end
        pick = $urandom_range(0, 7);
        if (pick == 1)
            push_text("000");
        else if (pick != 0)
            push_text("0");
        push_extension();
        push_line_end();
        n = $urandom_range(0, 2);
        for (int t = 0; t < n; t++)
        begin
            if ($urandom_range(0, 7) == 0)
                push_text("\r\r");
            else
            begin
                do
                    b = junk_byte();
                while (b == BYTE_CR);
                push_byte(b);
                size = $urandom_range(0, 4);
                for (int i = 0; i < size; i++)
                    push_byte(junk_byte());
            end
            push_line_end();
        end
        push_line_end();
    endtask

    task automatic push_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 2) == 0)
                push_byte(BYTE_LF);
            else
                push_byte(junk_byte());
    endtask

    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
        if (!in_valid || in_taken)
        begin
            if (rst_n && pending_bytes.size() > 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                in_valid <= 1'b1;
                in_byte <= pending_bytes.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        decoded_t want;
        in_taken = rst_n && in_valid && !in_stall;
        out_taken = rst_n && out_valid && !out_stall;
        if (in_taken)
        begin
            decode_byte(in_byte);
            bytes_in++;
        end
        if (out_taken)
        begin
            if (message_end === 1'b1)
                ends_seen++;
            else
                payload_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: expected no item, actual out_byte %02h message_end %b",
                         $time, out_byte, message_end);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_byte !== want.data)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.data, out_byte);
                    mismatches++;
                end
                if (message_end !== want.fin)
                begin
                    $display("%0t: message_end expected %b actual %b",
                             $time, want.fin, message_end);
                    mismatches++;
                end
            end
        end
        quiet_cycles = (in_taken || out_taken) ? 0 : quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, expected_results.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty body, oversized and extended sizes with extreme data, then a
        // size line without digits followed by a CR-only trailer line.
        push_text("0\n\n");
        push_text("100000002;5\n");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("\n");
        push_text("\n\r\r\n\r\n");

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            bytes_queued = 0;
            while (bytes_queued < PHASE_BYTES)
                if ($urandom_range(0, 9) == 0)
                    push_noise();
                else
                    push_message();
            while (pending_bytes.size() != 0)
                @(posedge clk);
        end

        while (pending_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("Sent %0d body bytes through four pacing phases; checked %0d payload bytes",
                 bytes_in, payload_seen);
        $display("and %0d ends of message, with %0d mismatches.", ends_seen, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

[filelist.f]
rtl/hcbd_pkg.sv
rtl/hcbd_in_stage.sv
rtl/hcbd_parser.sv
rtl/hcbd_out_stage.sv
rtl/http_chunked_body_decoder_unit.sv
rtl/hcbd_checker.sv
test/tb.sv
